// ===== design/tps_pkg.sv =====
package tps_pkg;

  localparam int unsigned PROFILE_DEPTH_DEF   = 64;
  localparam int unsigned WATCHDOG_RELOAD_DEF = 5;

  localparam int unsigned KIND_W      = 3;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned ENTRY_W     = 7;
  localparam int unsigned WORD32_W    = 32;
  localparam int unsigned WDOG_W      = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [7:0] READ_TYPE_CODE = 8'd3;

  localparam int unsigned FLAG_TIMEOUT = 0;
  localparam int unsigned FLAG_LAGGING = 1;
  localparam int unsigned FLAG_ONESHOT = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPEAT_MODE   = 2'd0,
    CFG_ENTRY_COUNT   = 2'd1,
    CFG_TRANSFER_TYPE = 2'd2
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK          = 3'd0,
    KIND_ENABLE        = 3'd1,
    KIND_DISABLE       = 3'd2,
    KIND_PROFILE_WRITE = 3'd3,
    KIND_RESTART       = 3'd4,
    KIND_WDOG_KICK     = 3'd5,
    KIND_DMA_DONE      = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    CMD_IDLE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_RUN   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ENG_INIT    = 2'd0,
    ENG_READY   = 2'd1,
    ENG_WORKING = 2'd2
  } eng_e;

endpackage

// ===== design/traffic_profile_sequencer_unit.sv =====
// Traffic profile sequencer.
// Input channel s_axis: one command word per handshake; tuser carries the kind
// (tick, enable, disable, profile write, restart, watchdog kick, dma done),
// tdata the profile entry fields and the cut-short bit.
// Output channel m_axis: exactly one status word per input word, in order,
// carrying engine status, flags, current entry and the DMA request.
// Configuration: write cfg_we_i with cfg_index_i and cfg_data_i while idle.
// An accepted word waits in the input register until the result register is free or is being taken.
// Throughput: one word per cycle while results are taken; the loop through the
// profile tables is a registered-read memory addressed by the next entry position,
// so the entry compare, next-position mux and table address need no stage between.
// Reset clears all control state and flags; the profile tables are undefined
// until written and need no clearing pass.
// A stalled receiver holds the result register; one further word is held in
// the input register, after which s_axis_tready drops.
module traffic_profile_sequencer_unit #(
  parameter int unsigned PROFILE_DEPTH   = tps_pkg::PROFILE_DEPTH_DEF,
  parameter int unsigned WATCHDOG_RELOAD = tps_pkg::WATCHDOG_RELOAD_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [5:0] entry_slot, [37:6] entry_duration, [69:38] entry_rate,
  // [70] transfer_cut_short, [71] zero
  input  logic [tps_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [2:0] kind
  input  logic [tps_pkg::KIND_W-1:0]          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] engine_status, [2] response_ok, [3] command_error, [4] timeout_flag,
  // [5] lagging_flag, [6] oneshot_done_flag, [13:7] current_entry,
  // [14] dma_request, [15] dma_is_read, [47:16] dma_rate
  output logic [tps_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [tps_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tps_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned AW  = (PROFILE_DEPTH > 1) ? $clog2(PROFILE_DEPTH) : 1;
  localparam int unsigned EW  = tps_pkg::ENTRY_W;
  localparam int unsigned DW  = tps_pkg::WORD32_W;
  localparam int unsigned WW  = tps_pkg::WDOG_W;
  localparam logic [31:0] DEPTH32 = 32'(PROFILE_DEPTH);

  // configuration
  logic          repeat_q;
  logic [EW-1:0] count_q;
  logic [7:0]    type_q;

  // input register
  logic                        in_valid_q;
  tps_pkg::kind_e              kind_q;
  logic [tps_pkg::SLOT_W-1:0]  slot_q;
  logic [DW-1:0]               dur_in_q;
  logic [DW-1:0]               rate_in_q;
  logic                        cut_q;

  // control state
  tps_pkg::cmd_e cmd_q, cmd_d;
  tps_pkg::eng_e eng_q, eng_d;
  logic          resp_q, resp_d;
  logic [2:0]    flags_q, flags_d;
  logic [EW-1:0] pos_q, pos_d;
  logic [DW-1:0] secs_q, secs_d;
  logic [WW-1:0] wdog_q, wdog_d;

  // result register
  logic                             out_valid_q;
  logic [tps_pkg::OUT_TDATA_W-1:0]  out_data_q, out_data_d;

  // profile tables
  logic [DW-1:0] dur_mem  [PROFILE_DEPTH];
  logic [DW-1:0] rate_mem [PROFILE_DEPTH];
  logic [DW-1:0] dur_rd_q, rate_a_rd_q, rate_b_rd_q, rate0_q;
  logic [DW-1:0] wdur_q, wrate_q;
  logic          hit_a_q, hit_b_q;
  logic [AW-1:0] ra_a, ra_b, wa;
  logic [EW-1:0] pos_d_inc;
  logic          wr_en;

  logic          proc;
  logic          err, req;
  logic [DW-1:0] req_rate;
  logic [DW-1:0] secs_inc, dur_a, rate_a, rate_b;
  logic [EW-1:0] nxt_pos;
  logic          va, vb;

  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_q <= 1'b0;
      count_q  <= '0;
      type_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tps_pkg::CFG_REPEAT_MODE:   repeat_q <= cfg_data_i[0];
        tps_pkg::CFG_ENTRY_COUNT:   count_q  <= cfg_data_i[EW-1:0];
        tps_pkg::CFG_TRANSFER_TYPE: type_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q    <= tps_pkg::kind_e'(s_axis_tuser);
      slot_q    <= s_axis_tdata[5:0];
      dur_in_q  <= s_axis_tdata[37:6];
      rate_in_q <= s_axis_tdata[69:38];
      cut_q     <= s_axis_tdata[70];
    end
  end

  // read effective table values, with bypass of a write at the last edge
  assign secs_inc = secs_q + 32'd1;
  assign nxt_pos  = pos_q + 7'd1;
  assign va       = 32'(pos_q) < DEPTH32;
  assign vb       = 32'(nxt_pos) < DEPTH32;
  assign dur_a    = va ? (hit_a_q ? wdur_q : dur_rd_q) : '0;
  assign rate_a   = va ? (hit_a_q ? wrate_q : rate_a_rd_q) : '0;
  assign rate_b   = vb ? (hit_b_q ? wrate_q : rate_b_rd_q) : '0;

  always_comb begin
    cmd_d    = cmd_q;
    eng_d    = eng_q;
    resp_d   = resp_q;
    flags_d  = flags_q;
    pos_d    = pos_q;
    secs_d   = secs_q;
    wdog_d   = wdog_q;
    err      = 1'b0;
    req      = 1'b0;
    req_rate = '0;
    wr_en    = 1'b0;
    if (proc) begin
      case (kind_q)
        tps_pkg::KIND_TICK: begin
          if (cmd_q == tps_pkg::CMD_RUN) begin
            flags_d = '0;
            if (wdog_q <= 3'd1) begin
              wdog_d                        = '0;
              resp_d                        = 1'b1;
              eng_d                         = tps_pkg::ENG_READY;
              cmd_d                         = tps_pkg::CMD_IDLE;
              flags_d[tps_pkg::FLAG_TIMEOUT] = 1'b1;
            end else begin
              wdog_d = wdog_q - 3'd1;
              eng_d  = tps_pkg::ENG_WORKING;
              req    = 1'b1;
              if (secs_inc >= dur_a) begin
                secs_d   = '0;
                pos_d    = nxt_pos;
                req_rate = rate_b;
                if (nxt_pos >= count_q) begin
                  pos_d = '0;
                  if (repeat_q) begin
                    req_rate = rate0_q;
                  end else begin
                    req                            = 1'b0;
                    req_rate                       = '0;
                    resp_d                         = 1'b1;
                    eng_d                          = tps_pkg::ENG_READY;
                    cmd_d                          = tps_pkg::CMD_IDLE;
                    flags_d[tps_pkg::FLAG_ONESHOT] = 1'b1;
                  end
                end
              end else begin
                secs_d   = secs_inc;
                req_rate = rate_a;
              end
            end
          end else if (cmd_q == tps_pkg::CMD_RESET) begin
            resp_d = 1'b1;
            eng_d  = tps_pkg::ENG_READY;
            cmd_d  = tps_pkg::CMD_IDLE;
          end
        end
        tps_pkg::KIND_ENABLE: begin
          if (eng_q != tps_pkg::ENG_READY) begin
            err = 1'b1;
          end else begin
            resp_d                         = 1'b0;
            wdog_d                         = WW'(WATCHDOG_RELOAD);
            flags_d[tps_pkg::FLAG_TIMEOUT] = 1'b0;
            pos_d                          = '0;
            secs_d                         = '0;
            cmd_d                          = tps_pkg::CMD_RUN;
          end
        end
        tps_pkg::KIND_DISABLE: begin
          resp_d = 1'b0;
          cmd_d  = tps_pkg::CMD_RESET;
        end
        tps_pkg::KIND_PROFILE_WRITE: begin
          wr_en = 32'(slot_q) < DEPTH32;
        end
        tps_pkg::KIND_RESTART: begin
          pos_d  = '0;
          secs_d = '0;
        end
        tps_pkg::KIND_WDOG_KICK: begin
          wdog_d = WW'(WATCHDOG_RELOAD);
        end
        tps_pkg::KIND_DMA_DONE: begin
          if (cmd_q == tps_pkg::CMD_RUN) begin
            if (cut_q) begin
              flags_d[tps_pkg::FLAG_LAGGING] = 1'b1;
            end
            resp_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data_d        = '0;
    out_data_d[1:0]   = eng_d;
    out_data_d[2]     = resp_d;
    out_data_d[3]     = err;
    out_data_d[4]     = flags_d[tps_pkg::FLAG_TIMEOUT];
    out_data_d[5]     = flags_d[tps_pkg::FLAG_LAGGING];
    out_data_d[6]     = flags_d[tps_pkg::FLAG_ONESHOT];
    out_data_d[13:7]  = pos_d;
    out_data_d[14]    = req;
    out_data_d[15]    = req && (type_q == tps_pkg::READ_TYPE_CODE);
    out_data_d[47:16] = req_rate;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= tps_pkg::CMD_IDLE;
      eng_q   <= tps_pkg::ENG_READY;
      resp_q  <= 1'b0;
      flags_q <= '0;
      pos_q   <= '0;
      secs_q  <= '0;
      wdog_q  <= '0;
    end else begin
      cmd_q   <= cmd_d;
      eng_q   <= eng_d;
      resp_q  <= resp_d;
      flags_q <= flags_d;
      pos_q   <= pos_d;
      secs_q  <= secs_d;
      wdog_q  <= wdog_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_data_q <= out_data_d;
    end
  end

  // address the tables by the position that the next word will see
  assign pos_d_inc = pos_d + 7'd1;
  assign ra_a      = AW'(32'(pos_d));
  assign ra_b      = AW'(32'(pos_d_inc));
  assign wa        = AW'(32'(slot_q));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dur_mem[wa]  <= dur_in_q;
      rate_mem[wa] <= rate_in_q;
    end
    dur_rd_q    <= dur_mem[ra_a];
    rate_a_rd_q <= rate_mem[ra_a];
    rate_b_rd_q <= rate_mem[ra_b];
  end

  always_ff @(posedge clk_i) begin
    wdur_q  <= dur_in_q;
    wrate_q <= rate_in_q;
    if (wr_en && (slot_q == '0)) begin
      rate0_q <= rate_in_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else begin
      hit_a_q <= wr_en && (wa == ra_a);
      hit_b_q <= wr_en && (wa == ra_b);
    end
  end

  a_req_working: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[14] |-> m_axis_tdata[1:0] == tps_pkg::ENG_WORKING)
    else $error("dma request without working status");

  a_err_no_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[14])
    else $error("refused enable with dma request");

  a_timeout_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && flags_d[tps_pkg::FLAG_TIMEOUT] && (kind_q == tps_pkg::KIND_TICK) &&
    (cmd_q == tps_pkg::CMD_RUN)
    |=> cmd_q == tps_pkg::CMD_IDLE && wdog_q == '0)
    else $error("watchdog expiry left engine running");

  a_oneshot_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && flags_d[tps_pkg::FLAG_ONESHOT] |=> pos_q == '0 && !m_axis_tdata[14])
    else $error("one-shot end did not return to entry zero");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled with room available");

endmodule

// ===== tb/traffic_profile_sequencer_unit_test.sv =====
module traffic_profile_sequencer_unit_test;

  localparam int unsigned DEPTH       = tps_pkg::PROFILE_DEPTH_DEF;
  localparam logic [2:0]  WDOG_RELOAD = 3'(tps_pkg::WATCHDOG_RELOAD_DEF);
  localparam logic [2:0]  KIND_UNUSED = 3'd7;
  localparam logic [2:0]  NO_FLAG     = 3'b000;
  localparam logic [2:0]  TIMEOUT_BIT = 3'(1 << tps_pkg::FLAG_TIMEOUT);
  localparam logic [2:0]  LAGGING_BIT = 3'(1 << tps_pkg::FLAG_LAGGING);
  localparam logic [2:0]  ONESHOT_BIT = 3'(1 << tps_pkg::FLAG_ONESHOT);
  localparam int          PHASES      = 8;
  localparam int          PHASE_WORDS = 112;
  localparam int          CYCLE_LIMIT = 200000;

  // layout of m_axis_tdata, highest field first
  typedef struct packed {
    logic [31:0] rate;
    logic        is_read;
    logic        req;
    logic [6:0]  entry;
    logic        oneshot;
    logic        lagging;
    logic        timeout;
    logic        err;
    logic        ok;
    logic [1:0]  status;
  } status_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [71:0] data;
    logic        typed;
    status_t     fixed;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // [5:0] entry_slot, [37:6] entry_duration, [69:38] entry_rate,
  // [70] transfer_cut_short, [71] zero
  logic [tps_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  // [2:0] kind
  logic [tps_pkg::KIND_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // [1:0] engine_status, [2] response_ok, [3] command_error, [4] timeout_flag,
  // [5] lagging_flag, [6] oneshot_done_flag, [13:7] current_entry,
  // [14] dma_request, [15] dma_is_read, [47:16] dma_rate
  logic [tps_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [tps_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  traffic_profile_sequencer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // sequencer shadow state
  tps_pkg::cmd_e p_cmd   = tps_pkg::CMD_IDLE;
  tps_pkg::eng_e p_eng   = tps_pkg::ENG_READY;
  logic          p_ok    = 1'b0;
  logic [2:0]    p_flags = '0;
  logic [6:0]    p_pos   = '0;
  logic [31:0]   p_secs  = '0;
  logic [2:0]    p_wdog  = '0;
  logic [31:0]   p_dur  [DEPTH];
  logic [31:0]   p_rate [DEPTH];
  logic          cf_repeat = 1'b0;
  logic [6:0]    cf_count  = '0;
  logic [7:0]    cf_type   = '0;

  status_t status_q [$];
  row_t    dir_rows [$];
  status_t exp_s;
  status_t got_s;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  int      words_checked  = 0;
  int      mismatches     = 0;
  int      cycle_count    = 0;

  function automatic logic [71:0] pack_word(logic [5:0] slot, logic [31:0] dur,
                                            logic [31:0] rate, logic cut);
    return {1'b0, cut, rate, dur, slot};
  endfunction

  function automatic status_t status_of(logic [1:0] st, logic ok, logic err,
                                        logic [2:0] flags, logic [6:0] entry);
    status_t r;
    r         = '0;
    r.status  = st;
    r.ok      = ok;
    r.err     = err;
    r.timeout = flags[tps_pkg::FLAG_TIMEOUT];
    r.lagging = flags[tps_pkg::FLAG_LAGGING];
    r.oneshot = flags[tps_pkg::FLAG_ONESHOT];
    r.entry   = entry;
    return r;
  endfunction

  function automatic void stop_run(logic [2:0] flag);
    p_ok    = 1'b1;
    p_eng   = tps_pkg::ENG_READY;
    p_cmd   = tps_pkg::CMD_IDLE;
    p_flags = p_flags | flag;
  endfunction

  function automatic status_t predict_status(logic [2:0] k, logic [71:0] d);
    logic [5:0]  slot;
    logic [31:0] dur;
    logic [31:0] rate;
    logic        cut;
    logic        err;
    logic        stopped;
    status_t     r;
    slot    = d[5:0];
    dur     = d[37:6];
    rate    = d[69:38];
    cut     = d[70];
    err     = 1'b0;
    stopped = 1'b0;
    r       = '0;
    case (k)
      tps_pkg::KIND_TICK: begin
        if (p_cmd == tps_pkg::CMD_RUN) begin
          p_flags = '0;
          if (p_wdog <= 3'd1) begin
            p_wdog = '0;
            stop_run(TIMEOUT_BIT);
          end else begin
            p_wdog = p_wdog - 3'd1;
            p_eng  = tps_pkg::ENG_WORKING;
            p_secs = p_secs + 32'd1;
            if (p_secs >= ((p_pos < DEPTH) ? p_dur[p_pos] : 32'd0)) begin
              p_pos  = p_pos + 7'd1;
              p_secs = '0;
              if (p_pos >= cf_count) begin
                if (!cf_repeat) begin
                  stop_run(ONESHOT_BIT);
                  stopped = 1'b1;
                end
                p_pos = '0;
              end
            end
            if (!stopped) begin
              r.req     = 1'b1;
              r.is_read = (cf_type == tps_pkg::READ_TYPE_CODE);
              r.rate    = (p_pos < DEPTH) ? p_rate[p_pos] : 32'd0;
            end
          end
        end else if (p_cmd == tps_pkg::CMD_RESET) begin
          stop_run(NO_FLAG);
        end
      end
      tps_pkg::KIND_ENABLE: begin
        if (p_eng != tps_pkg::ENG_READY) begin
          err = 1'b1;
        end else begin
          p_ok    = 1'b0;
          p_wdog  = WDOG_RELOAD;
          p_flags = p_flags & ~TIMEOUT_BIT;
          p_pos   = '0;
          p_secs  = '0;
          p_cmd   = tps_pkg::CMD_RUN;
        end
      end
      tps_pkg::KIND_DISABLE: begin
        p_ok  = 1'b0;
        p_cmd = tps_pkg::CMD_RESET;
      end
      tps_pkg::KIND_PROFILE_WRITE: begin
        if (slot < DEPTH) begin
          p_dur[slot]  = dur;
          p_rate[slot] = rate;
        end
      end
      tps_pkg::KIND_RESTART: begin
        p_pos  = '0;
        p_secs = '0;
      end
      tps_pkg::KIND_WDOG_KICK: p_wdog = WDOG_RELOAD;
      tps_pkg::KIND_DMA_DONE: begin
        if (p_cmd == tps_pkg::CMD_RUN) begin
          if (cut) p_flags = p_flags | LAGGING_BIT;
          p_ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.status  = p_eng;
    r.ok      = p_ok;
    r.err     = err;
    r.timeout = p_flags[tps_pkg::FLAG_TIMEOUT];
    r.lagging = p_flags[tps_pkg::FLAG_LAGGING];
    r.oneshot = p_flags[tps_pkg::FLAG_ONESHOT];
    r.entry   = p_pos;
    return r;
  endfunction

  task automatic add_row(logic [2:0] k, logic [5:0] slot, logic [31:0] dur,
                         logic [31:0] rate, logic cut, logic typed, status_t fixed);
    row_t r;
    r.kind  = k;
    r.data  = pack_word(slot, dur, rate, cut);
    r.typed = typed;
    r.fixed = fixed;
    dir_rows.push_back(r);
  endtask

  task automatic send_word(logic [2:0] k, logic [71:0] d, logic typed, status_t fixed);
    status_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    e = predict_status(k, d);
    status_q.push_back(typed ? fixed : e);
  endtask

  task automatic send_random_word();
    logic [2:0]  k;
    logic [31:0] dur;
    int          roll;
    roll = $urandom_range(99);
    if (p_cmd != tps_pkg::CMD_RUN && roll < 50) begin
      k = tps_pkg::KIND_ENABLE;
    end else begin
      roll = $urandom_range(99);
      if (roll < 40)      k = tps_pkg::KIND_TICK;
      else if (roll < 62) k = tps_pkg::KIND_WDOG_KICK;
      else if (roll < 72) k = tps_pkg::KIND_DMA_DONE;
      else if (roll < 78) k = tps_pkg::KIND_ENABLE;
      else if (roll < 83) k = tps_pkg::KIND_DISABLE;
      else if (roll < 88) k = tps_pkg::KIND_RESTART;
      else if (roll < 96) k = tps_pkg::KIND_PROFILE_WRITE;
      else                k = KIND_UNUSED;
    end
    roll = $urandom_range(99);
    if (k != tps_pkg::KIND_PROFILE_WRITE || roll >= 90) dur = $urandom;
    else if (roll < 70)                                 dur = $urandom_range(3);
    else                                                dur = $urandom_range(40);
    send_word(k, pack_word(6'($urandom), dur, $urandom, 1'($urandom)), 1'b0, '0);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic rep, logic [7:0] cnt, logic [7:0] typ);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= tps_pkg::CFG_REPEAT_MODE;
    cfg_data_i  <= 8'(rep);
    @(posedge clk_i);
    cfg_index_i <= tps_pkg::CFG_ENTRY_COUNT;
    cfg_data_i  <= cnt;
    @(posedge clk_i);
    cfg_index_i <= tps_pkg::CFG_TRANSFER_TYPE;
    cfg_data_i  <= typ;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cf_repeat = rep;
    cf_count  = cnt[6:0];
    cf_type   = typ;
  endtask

  task automatic compare_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h got %0h", $time, name, e, a);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (status_q.size() == 0) begin
        $display("%0t: word with nothing expected, expected none got %0h", $time,
                 m_axis_tdata);
        mismatches++;
      end else begin
        exp_s = status_q.pop_front();
        got_s = status_t'(m_axis_tdata);
        compare_field("engine_status", exp_s.status, got_s.status);
        compare_field("response_ok", exp_s.ok, got_s.ok);
        compare_field("command_error", exp_s.err, got_s.err);
        compare_field("timeout_flag", exp_s.timeout, got_s.timeout);
        compare_field("lagging_flag", exp_s.lagging, got_s.lagging);
        compare_field("oneshot_done_flag", exp_s.oneshot, got_s.oneshot);
        compare_field("current_entry", exp_s.entry, got_s.entry);
        compare_field("dma_request", exp_s.req, got_s.req);
        compare_field("dma_is_read", exp_s.is_read, got_s.is_read);
        compare_field("dma_rate", exp_s.rate, got_s.rate);
        words_checked++;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    status_t    rdy;
    status_t    none;
    logic       rep;
    logic [7:0] cnt;
    logic [7:0] typ;
    rdy  = status_of(tps_pkg::ENG_READY, 1'b0, 1'b0, NO_FLAG, 7'd0);
    none = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apply_setting(1'b0, 8'd2, tps_pkg::READ_TYPE_CODE);

    add_row(tps_pkg::KIND_TICK, 6'd0, 32'd0, 32'd0, 1'b0, 1'b1, rdy);
    add_row(KIND_UNUSED, 6'h3f, 32'hffffffff, 32'hffffffff, 1'b1, 1'b1, rdy);
    add_row(tps_pkg::KIND_DMA_DONE, 6'd0, 32'd0, 32'd0, 1'b1, 1'b1, rdy);
    add_row(tps_pkg::KIND_PROFILE_WRITE, 6'd0, 32'd1, 32'hffffffff, 1'b0, 1'b1, rdy);
    add_row(tps_pkg::KIND_PROFILE_WRITE, 6'd1, 32'd0, 32'd0, 1'b0, 1'b1, rdy);
    add_row(tps_pkg::KIND_PROFILE_WRITE, 6'h3f, 32'hffffffff, 32'h12345678, 1'b1,
            1'b1, rdy);
    add_row(tps_pkg::KIND_WDOG_KICK, 6'd0, 32'd0, 32'd0, 1'b0, 1'b1, rdy);
    add_row(tps_pkg::KIND_DISABLE, 6'd0, 32'd0, 32'd0, 1'b0, 1'b1, rdy);
    add_row(tps_pkg::KIND_TICK, 6'd0, 32'd0, 32'd0, 1'b0, 1'b1,
            status_of(tps_pkg::ENG_READY, 1'b1, 1'b0, NO_FLAG, 7'd0));
    add_row(tps_pkg::KIND_ENABLE, 6'd0, 32'd0, 32'd0, 1'b0, 1'b1, rdy);
    add_row(tps_pkg::KIND_ENABLE, 6'd0, 32'd0, 32'd0, 1'b0, 1'b1, rdy);
    add_row(tps_pkg::KIND_TICK, 6'd0, 32'd0, 32'd0, 1'b0, 1'b0, none);
    add_row(tps_pkg::KIND_ENABLE, 6'd0, 32'd0, 32'd0, 1'b0, 1'b1,
            status_of(tps_pkg::ENG_WORKING, 1'b0, 1'b1, NO_FLAG, 7'd1));
    add_row(tps_pkg::KIND_DMA_DONE, 6'd0, 32'd0, 32'd0, 1'b1, 1'b0, none);
    add_row(tps_pkg::KIND_TICK, 6'd0, 32'd0, 32'd0, 1'b0, 1'b0, none);
    add_row(tps_pkg::KIND_ENABLE, 6'd0, 32'd0, 32'd0, 1'b0, 1'b0, none);
    add_row(tps_pkg::KIND_TICK, 6'd0, 32'd0, 32'd0, 1'b0, 1'b0, none);
    add_row(tps_pkg::KIND_RESTART, 6'd0, 32'd0, 32'd0, 1'b0, 1'b0, none);
    add_row(tps_pkg::KIND_PROFILE_WRITE, 6'd0, 32'hffffffff, 32'hffffffff, 1'b0,
            1'b0, none);
    add_row(tps_pkg::KIND_TICK, 6'd0, 32'd0, 32'd0, 1'b0, 1'b0, none);
    add_row(tps_pkg::KIND_TICK, 6'd0, 32'd0, 32'd0, 1'b0, 1'b0, none);
    add_row(tps_pkg::KIND_TICK, 6'd0, 32'd0, 32'd0, 1'b0, 1'b0, none);
    add_row(tps_pkg::KIND_TICK, 6'd0, 32'd0, 32'd0, 1'b0, 1'b1,
            status_of(tps_pkg::ENG_READY, 1'b1, 1'b0, TIMEOUT_BIT, 7'd0));
    add_row(tps_pkg::KIND_WDOG_KICK, 6'd0, 32'd0, 32'd0, 1'b0, 1'b1,
            status_of(tps_pkg::ENG_READY, 1'b1, 1'b0, TIMEOUT_BIT, 7'd0));
    add_row(tps_pkg::KIND_TICK, 6'd0, 32'd0, 32'd0, 1'b0, 1'b1,
            status_of(tps_pkg::ENG_READY, 1'b1, 1'b0, TIMEOUT_BIT, 7'd0));

    foreach (dir_rows[i]) send_word(dir_rows[i].kind, dir_rows[i].data,
                                    dir_rows[i].typed, dir_rows[i].fixed);
    drain_results();

    // load every slot so that no entry is read before it is written
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    for (int slot = 0; slot < DEPTH; slot++) begin
      send_word(tps_pkg::KIND_PROFILE_WRITE,
                pack_word(6'(slot), $urandom_range(3), $urandom, 1'($urandom)),
                1'b0, '0);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       begin rep = 1'b0; cnt = 8'd0;  typ = 8'd0;   end
        1:       begin rep = 1'b1; cnt = 8'd64; typ = 8'd3;   end
        2:       begin rep = 1'b1; cnt = 8'd1;  typ = 8'd255; end
        3:       begin rep = 1'b0; cnt = 8'd64; typ = 8'd2;   end
        4:       begin rep = 1'b1; cnt = 8'd5;  typ = 8'd3;   end
        5:       begin rep = 1'b0; cnt = 8'd3;  typ = 8'd4;   end
        6:       begin rep = 1'($urandom); cnt = 8'($urandom_range(64)); typ = 8'($urandom); end
        default: begin rep = 1'b0; cnt = 8'd63; typ = 8'd1;   end
      endcase
      apply_setting(rep, cnt, typ);
      case (phase % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      repeat (PHASE_WORDS) send_random_word();
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    $display("%0d status words checked: directed table, profile load and %0d random phases",
             words_checked, PHASES);
    $display("covering repeat and one-shot runs, watchdog expiry and four idling patterns");
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== traffic_profile_sequencer_unit.f =====
design/tps_pkg.sv
design/traffic_profile_sequencer_unit.sv
tb/traffic_profile_sequencer_unit_test.sv
